### hdl/mlp_pkg.sv
package mlp_pkg;

	localparam int unsigned ACC_W = 40;
	localparam logic [63:0] EXP_STEP_Q32 = 64'd4162825044;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_ROUND,
		ST_SCALE,
		ST_SIG,
		ST_WRITE,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		REG_SCALE,
		REG_LAYERS,
		REG_WIDTH0,
		REG_WIDTH1,
		REG_WIDTH2,
		REG_WIDTH3,
		REG_WIDTH4
	} reg_idx_t;

	typedef logic [255:0][15:0] sig_tab_t;

	// Logistic function in unsigned Q0.16 at the bin midpoints of [-8, 8).
	function automatic sig_tab_t build_sig_table();
		sig_tab_t tab;
		logic [63:0] e;
		logic [63:0] den;
		logic [63:0] num;
		logic [63:0] rem;
		logic [63:0] pos;
		logic [16:0] neg;
		int steps;
		for (int k = 128; k < 256; k++) begin
			e = 64'h1_0000_0000;
			steps = 2 * k - 255;
			for (int m = 0; m < steps; m++) begin
				e = (e * EXP_STEP_Q32) >> 32;
			end
			den = 64'h1_0000_0000 + e;
			num = (64'd1 << 48) + (den >> 1);
			// Restoring long division, one quotient bit per step.
			rem = '0;
			pos = '0;
			for (int b = 63; b >= 0; b--) begin
				rem = {rem[62:0], num[b]};
				if (rem >= den) begin
					rem = rem - den;
					pos[b] = 1'b1;
				end
			end
			tab[k] = pos[15:0];
			neg = 17'h1_0000 - pos[16:0];
			tab[255 - k] = neg[15:0];
		end
		return tab;
	endfunction

	localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage

### hdl/mlp_silu_inference.sv
// Fully connected network inference engine with a scaled SiLU activation on every hidden layer
// and a linear output layer. Weights are loaded as transactions with mode low, each one writing
// the word at layer*MAX_WIDTH*MAX_WIDTH + row*MAX_WIDTH + col; words beyond WEIGHT_DEPTH are
// dropped. Feature elements follow with mode high, and the element flagged by last starts the
// forward pass; elements not delivered read as zero and elements beyond MAX_WIDTH are dropped.
// All data is Q4.12. Every layer runs on one shared 16x16 multiplier with a 40-bit accumulator,
// one multiply-accumulate per cycle, reading weight and activation memories with registered
// reads. Weight writes and ordinary feature elements are accepted while idle; the flagged one
// starts the pass, which per row runs the MAC loop over the input width, then for hidden rows
// scales, applies the sigmoid and writes back, and for output rows waits on the result channel.
// The input channel is not ready while a pass is running. Results leave one transaction per
// output node through a single output register, with out_last set on the final node.
module mlp_silu_inference #(
	parameter int unsigned MAX_WIDTH = 16,
	parameter int unsigned MAX_LAYERS = 5,
	parameter int unsigned WEIGHT_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        mode,
	input  logic [9:0]  weight_address,
	input  logic signed [15:0] value,
	input  logic        last,
	output logic        result_valid,
	input  logic        result_ready,
	output logic signed [15:0] out_value,
	output logic [3:0]  out_index,
	output logic        out_last
);

	localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned BD = 2 * MAX_WIDTH;
	localparam int unsigned BW = $clog2(BD);
	localparam int unsigned WA = $clog2(WEIGHT_DEPTH);
	localparam int unsigned MW2 = MAX_WIDTH * MAX_WIDTH;
	localparam int unsigned TOP_L = (MAX_LAYERS < 5) ? MAX_LAYERS : 5;
	localparam int unsigned ACC_W = mlp_pkg::ACC_W;

	// Configuration registers, kept as written and clamped where they are used.
	logic signed [15:0] scale_q;
	logic [2:0]         layers_q;
	logic [4:0]         width_q [5];

	mlp_pkg::state_t state_q, state_d;

	logic [CW-1:0] fc_q;
	logic [CW-1:0] nfeat_q;
	logic [2:0]    layer_q;
	logic [CW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic          cur_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [15:0] z_q;
	logic signed [48:0] t_q;

	logic signed [15:0] w_s1, a_s1;
	logic wz_s1, az_s1, v_s1;
	logic signed [31:0] prod_s2;
	logic v_s2;

	logic signed [15:0] wmem [WEIGHT_DEPTH];
	logic signed [15:0] bank [BD];

	logic out_v_q;
	logic signed [15:0] out_value_q;
	logic [3:0] out_index_q;
	logic out_last_q;

	function automatic logic [CW-1:0] clamp_w(input logic [4:0] raw);
		int unsigned w;
		w = 32'(raw);
		if (w < 1) w = 1;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		return CW'(w);
	endfunction

	function automatic logic [4:0] width_of(input logic [2:0] l);
		logic [4:0] w;
		case (l)
			3'd0: w = width_q[0];
			3'd1: w = width_q[1];
			3'd2: w = width_q[2];
			3'd3: w = width_q[3];
			3'd4: w = width_q[4];
			default: w = 5'd1;
		endcase
		return w;
	endfunction

	// Saturate a wide signed value to 16 bits.
	function automatic logic signed [15:0] sat16(input logic signed [48:0] v);
		logic signed [15:0] r;
		if (v > 49'sd32767) r = 16'sh7fff;
		else if (v < -49'sd32768) r = -16'sh8000;
		else r = v[15:0];
		return r;
	endfunction

	// Sequencing values.
	logic [2:0]    nl;
	logic [2:0]    last_l;
	logic [CW-1:0] w_in, w_out;
	logic          last_layer, last_col, last_row;
	logic          in_fire, feat_go, out_load;
	logic [CW-1:0] fc_next;

	always_comb begin
		nl = layers_q;
		if (nl < 3'd2) nl = 3'd2;
		if (32'(nl) > TOP_L) nl = 3'(TOP_L);
	end

	assign last_l     = nl - 3'd2;
	assign w_in       = clamp_w(width_of(layer_q));
	assign w_out      = clamp_w(width_of(layer_q + 3'd1));
	assign last_layer = (layer_q == last_l);
	assign last_col   = (col_q == w_in - CW'(1));
	assign last_row   = (row_q == w_out - CW'(1));

	assign item_ready = (state_q == mlp_pkg::ST_IDLE);
	assign in_fire    = item_valid && item_ready;
	assign feat_go    = in_fire && mode && last;
	assign fc_next    = (32'(fc_q) < MAX_WIDTH) ? fc_q + CW'(1) : fc_q;
	assign out_load   = (state_q == mlp_pkg::ST_OUT) && (!out_v_q || result_ready);

	// APB register file.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= 16'sd4096;
			layers_q <= 3'd3;
			for (int i = 0; i < 5; i++) width_q[i] <= 5'd16;
		end else if (psel && penable && pwrite) begin
			case (mlp_pkg::reg_idx_t'(paddr[4:2]))
				mlp_pkg::REG_SCALE:  scale_q    <= pwdata[15:0];
				mlp_pkg::REG_LAYERS: layers_q   <= pwdata[2:0];
				mlp_pkg::REG_WIDTH0: width_q[0] <= pwdata[4:0];
				mlp_pkg::REG_WIDTH1: width_q[1] <= pwdata[4:0];
				mlp_pkg::REG_WIDTH2: width_q[2] <= pwdata[4:0];
				mlp_pkg::REG_WIDTH3: width_q[3] <= pwdata[4:0];
				mlp_pkg::REG_WIDTH4: width_q[4] <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (mlp_pkg::reg_idx_t'(paddr[4:2]))
			mlp_pkg::REG_SCALE:  prdata = {16'd0, scale_q};
			mlp_pkg::REG_LAYERS: prdata = {29'd0, layers_q};
			mlp_pkg::REG_WIDTH0: prdata = {27'd0, width_q[0]};
			mlp_pkg::REG_WIDTH1: prdata = {27'd0, width_q[1]};
			mlp_pkg::REG_WIDTH2: prdata = {27'd0, width_q[2]};
			mlp_pkg::REG_WIDTH3: prdata = {27'd0, width_q[3]};
			mlp_pkg::REG_WIDTH4: prdata = {27'd0, width_q[4]};
			default: prdata = 32'd0;
		endcase
	end

	// Weight memory: written by load transactions, read by the MAC loop.
	logic [31:0] wr_addr32, rd_addr32;
	logic        w_wr, w_in_range;

	assign wr_addr32  = 32'(weight_address);
	assign w_wr       = in_fire && !mode && (wr_addr32 < WEIGHT_DEPTH);
	assign rd_addr32  = 32'(layer_q) * MW2 + 32'(row_q) * MAX_WIDTH + 32'(col_q);
	assign w_in_range = (rd_addr32 < WEIGHT_DEPTH);

	always_ff @(posedge clk) begin
		if (w_wr) wmem[wr_addr32[WA-1:0]] <= value;
		w_s1 <= wmem[rd_addr32[WA-1:0]];
	end

	// Activation memory: two banks of MAX_WIDTH words, swapped layer by layer.
	logic [31:0] b_wr32, b_rd32;
	logic        b_wr;
	logic signed [15:0] b_wdata;
	logic signed [48:0] t_round;
	logic signed [15:0] act_out;

	assign t_round = (t_q + (49'sd1 <<< 27)) >>> 28;
	assign act_out = sat16(t_round);

	always_comb begin
		b_wr    = 1'b0;
		b_wr32  = 32'(fc_q);
		b_wdata = value;
		if (state_q == mlp_pkg::ST_WRITE) begin
			b_wr    = 1'b1;
			b_wr32  = 32'(!cur_q) * MAX_WIDTH + 32'(row_q);
			b_wdata = act_out;
		end else if (in_fire && mode && (32'(fc_q) < MAX_WIDTH)) begin
			b_wr = 1'b1;
		end
	end

	assign b_rd32 = 32'(cur_q) * MAX_WIDTH + 32'(col_q);

	always_ff @(posedge clk) begin
		if (b_wr) bank[b_wr32[BW-1:0]] <= b_wdata;
		a_s1 <= bank[b_rd32[BW-1:0]];
	end

	// Shared multiplier: MAC products, then scale times pre-activation.
	logic signed [15:0] mul_a, mul_b;
	logic signed [31:0] mul_p;

	always_comb begin
		if (state_q == mlp_pkg::ST_SCALE) begin
			mul_a = scale_q;
			mul_b = z_q;
		end else begin
			mul_a = wz_s1 ? 16'sd0 : w_s1;
			mul_b = az_s1 ? 16'sd0 : a_s1;
		end
	end

	assign mul_p = mul_a * mul_b;

	// Rounded and saturated pre-activation from the accumulator.
	logic signed [ACC_W-1:0] acc_sh;
	logic signed [15:0] z_sat;

	assign acc_sh = (acc_q + ACC_W'(2048)) >>> 12;
	assign z_sat  = sat16(49'(acc_sh));

	logic [7:0]  sig_idx;
	logic signed [16:0] sig_val;

	assign sig_idx = {~z_q[15], z_q[14:8]};
	assign sig_val = signed'({1'b0, mlp_pkg::SIG_TABLE[sig_idx]});

	// State register and next state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mlp_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mlp_pkg::ST_IDLE:  if (feat_go) state_d = mlp_pkg::ST_MAC;
			mlp_pkg::ST_MAC:   if (last_col) state_d = mlp_pkg::ST_DRAIN;
			mlp_pkg::ST_DRAIN: if (!v_s1 && !v_s2) state_d = mlp_pkg::ST_ROUND;
			mlp_pkg::ST_ROUND: state_d = last_layer ? mlp_pkg::ST_OUT : mlp_pkg::ST_SCALE;
			mlp_pkg::ST_SCALE: state_d = mlp_pkg::ST_SIG;
			mlp_pkg::ST_SIG:   state_d = mlp_pkg::ST_WRITE;
			mlp_pkg::ST_WRITE: state_d = mlp_pkg::ST_MAC;
			mlp_pkg::ST_OUT: begin
				if (out_load) state_d = last_row ? mlp_pkg::ST_IDLE : mlp_pkg::ST_MAC;
			end
			default: state_d = mlp_pkg::ST_IDLE;
		endcase
	end

	// Sequencer counters and control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q    <= '0;
			nfeat_q <= '0;
			layer_q <= '0;
			row_q   <= '0;
			col_q   <= '0;
			cur_q   <= 1'b0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			v_s1 <= (state_q == mlp_pkg::ST_MAC);
			v_s2 <= v_s1;
			if (out_load) out_v_q <= 1'b1;
			else if (result_ready) out_v_q <= 1'b0;
			case (state_q)
				mlp_pkg::ST_IDLE: begin
					if (in_fire && mode) begin
						if (last) begin
							fc_q    <= '0;
							nfeat_q <= fc_next;
							layer_q <= '0;
							row_q   <= '0;
							col_q   <= '0;
							cur_q   <= 1'b0;
						end else begin
							fc_q <= fc_next;
						end
					end
				end
				mlp_pkg::ST_MAC: col_q <= col_q + CW'(1);
				mlp_pkg::ST_WRITE: begin
					col_q <= '0;
					if (last_row) begin
						row_q   <= '0;
						layer_q <= layer_q + 3'd1;
						cur_q   <= !cur_q;
					end else begin
						row_q <= row_q + CW'(1);
					end
				end
				mlp_pkg::ST_OUT: begin
					if (out_load) begin
						col_q <= '0;
						row_q <= row_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		wz_s1 <= !w_in_range;
		az_s1 <= (layer_q == 3'd0) && (col_q >= nfeat_q);
		if (v_s1 || state_q == mlp_pkg::ST_SCALE) prod_s2 <= mul_p;
		if (state_q == mlp_pkg::ST_IDLE || state_q == mlp_pkg::ST_WRITE
				|| state_q == mlp_pkg::ST_OUT) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
		if (state_q == mlp_pkg::ST_ROUND) z_q <= z_sat;
		if (state_q == mlp_pkg::ST_SIG) t_q <= 49'(prod_s2) * 49'(sig_val);
		if (out_load) begin
			out_value_q <= z_q;
			out_index_q <= 4'(row_q);
			out_last_q  <= last_row;
		end
	end

	assign result_valid = out_v_q;
	assign out_value    = out_value_q;
	assign out_index    = out_index_q;
	assign out_last     = out_last_q;

endmodule

### sim/mlp_silu_inference_tb.sv
module mlp_silu_inference_tb;

	// The watchdog trips when this many cycles in a row pass without a transaction on either
	// channel. The limit lies well above a full five-layer pass at maximum width and the longest
	// receiver hold-off, HOLD_CYCLES, which leaves a wide margin.
	localparam int unsigned STALL_LIMIT = 30000;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned SETTLE_CYCLES = 12;
	// Widths of layers one to three stay at or below this, so every pass reads only words
	// inside the preloaded region.
	localparam int unsigned HID_MAX = 5;

	typedef struct packed {
		logic signed [15:0] value;
		logic [3:0]         index;
		logic               last;
	} node_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic        mode = 1'b0;
	logic [9:0]  weight_address = '0;
	logic signed [15:0] value = '0;
	logic        last = 1'b0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic signed [15:0] out_value;
	logic [3:0]  out_index;
	logic        out_last;

	mlp_silu_inference dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow copy of the network: weights, the two activation banks, the feature counter and
	// the register file. The expected output vector is worked out as soon as the flagged
	// feature element is accepted, so the queue always holds every result still owed.
	logic [15:0] logistic_lut [256];
	logic signed [15:0] weights_sh [1024];
	logic signed [15:0] act_bank [32];
	int unsigned features_held;
	logic signed [15:0] scale_sh;
	logic [2:0]  depth_sh;
	logic [4:0]  width_sh [5];
	node_result_t pending_outputs [$];

	int unsigned errors = 0;
	int unsigned items_sent = 0;
	int unsigned results_seen = 0;
	int unsigned passes_run = 0;
	bit          quiet = 1'b0;
	int unsigned hold_seq = 0;

	// The logistic table is built here from the same recipe the hardware uses: each entry in
	// the upper half needs two more truncating steps of e^(-1/32) than the one before, so the
	// running product is simply carried from one entry to the next.
	function automatic void build_logistic();
		logic [63:0] e;
		logic [63:0] den;
		logic [63:0] pos;
		e = 64'h1_0000_0000;
		e = (e * 64'd4162825044) >> 32;
		for (int k = 128; k < 256; k++) begin
			if (k > 128) begin
				e = (e * 64'd4162825044) >> 32;
				e = (e * 64'd4162825044) >> 32;
			end
			den = 64'h1_0000_0000 + e;
			pos = ((64'd1 << 48) + den / 2) / den;
			logistic_lut[k] = pos[15:0];
			logistic_lut[255 - k] = 16'(17'h1_0000 - pos[16:0]);
		end
	endfunction

	function automatic logic signed [15:0] clip16(longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return 16'(v);
	endfunction

	function automatic int unsigned clamped_width(int unsigned l);
		int unsigned w;
		w = width_sh[l];
		if (w < 1) w = 1;
		if (w > 16) w = 16;
		return w;
	endfunction

	// Rounded matrix-vector row: the rounding adds half an LSB and then floors.
	function automatic logic signed [15:0] neuron_sum(int unsigned l, int unsigned r,
			int unsigned n, int unsigned bank);
		longint acc;
		acc = 0;
		for (int unsigned c = 0; c < n; c++)
			acc += longint'(weights_sh[l * 256 + r * 16 + c]) * longint'(act_bank[bank * 16 + c]);
		return clip16((acc + 2048) >>> 12);
	endfunction

	function automatic void forward_pass();
		int unsigned nl;
		int unsigned w_in;
		int unsigned w_out;
		int unsigned cur;
		logic signed [15:0] z;
		logic [15:0] biased;
		longint prod;
		node_result_t res;
		nl = depth_sh;
		if (nl < 2) nl = 2;
		if (nl > 5) nl = 5;
		w_in = clamped_width(0);
		for (int unsigned r = features_held; r < w_in; r++) act_bank[r] = '0;
		features_held = 0;
		cur = 0;
		for (int unsigned l = 0; l + 2 < nl; l++) begin
			w_in = clamped_width(l);
			w_out = clamped_width(l + 1);
			for (int unsigned r = 0; r < w_out; r++) begin
				z = neuron_sum(l, r, w_in, cur);
				biased = z + 16'h8000;
				prod = longint'(scale_sh) * longint'(z) * longint'({1'b0, logistic_lut[biased[15:8]]});
				act_bank[(cur ^ 1) * 16 + r] = clip16((prod + (64'sd1 <<< 27)) >>> 28);
			end
			cur ^= 1;
		end
		w_in = clamped_width(nl - 2);
		w_out = clamped_width(nl - 1);
		for (int unsigned r = 0; r < w_out; r++) begin
			res.value = neuron_sum(nl - 2, r, w_in, cur);
			res.index = 4'(r);
			res.last = (r + 1 == w_out);
			pending_outputs.insert(pending_outputs.size(), res);
		end
		passes_run++;
	endfunction

	function automatic void absorb_item(logic m, logic [9:0] a, logic signed [15:0] v, logic l);
		if (!m) begin
			weights_sh[a] = v;
			return;
		end
		if (features_held < 16) begin
			act_bank[features_held] = v;
			features_held++;
		end
		if (l) forward_pass();
	endfunction

	// Offers one transaction and returns at the edge that accepts it. Valid is left high so
	// that a following call can present the next item without a gap; a random gap first drops
	// valid and then waits.
	task automatic send_item(logic m, logic [9:0] a, logic signed [15:0] v, logic l);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		item_valid <= 1'b1;
		mode <= m;
		weight_address <= a;
		value <= v;
		last <= l;
		do @(negedge clk); while (!item_ready);
		@(posedge clk);
		items_sent++;
		absorb_item(m, a, v, l);
	endtask

	task automatic park_input();
		item_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [15:0] pick_value();
		case ($urandom_range(0, 4))
			0: return 16'($urandom);
			1: return 16'sh7fff - 16'($urandom_range(0, 3));
			2: return 16'sh8000 + 16'($urandom_range(0, 3));
			3: return 16'($signed($urandom_range(0, 8192)) - 4096);
			default: return 16'($signed($urandom_range(0, 2048)) - 1024);
		endcase
	endfunction

	// Waits for every owed result, then lets the engine settle before a register write.
	task automatic drain_outputs();
		park_input();
		while (pending_outputs.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(mlp_pkg::reg_idx_t idx, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			mlp_pkg::REG_SCALE:  scale_sh = data[15:0];
			mlp_pkg::REG_LAYERS: depth_sh = data[2:0];
			mlp_pkg::REG_WIDTH0: width_sh[0] = data[4:0];
			mlp_pkg::REG_WIDTH1: width_sh[1] = data[4:0];
			mlp_pkg::REG_WIDTH2: width_sh[2] = data[4:0];
			mlp_pkg::REG_WIDTH3: width_sh[3] = data[4:0];
			default:             width_sh[4] = data[4:0];
		endcase
	endtask

	task automatic set_network(logic [15:0] sc, logic [2:0] nl, logic [4:0] w0, logic [4:0] w1,
			logic [4:0] w2, logic [4:0] w3, logic [4:0] w4);
		drain_outputs();
		write_register(mlp_pkg::REG_SCALE, {16'($urandom), sc});
		write_register(mlp_pkg::REG_LAYERS, {29'($urandom), nl});
		write_register(mlp_pkg::REG_WIDTH0, {27'($urandom), w0});
		write_register(mlp_pkg::REG_WIDTH1, {27'($urandom), w1});
		write_register(mlp_pkg::REG_WIDTH2, {27'($urandom), w2});
		write_register(mlp_pkg::REG_WIDTH3, {27'($urandom), w3});
		write_register(mlp_pkg::REG_WIDTH4, {27'($urandom), w4});
		@(posedge clk);
	endtask

	// One feature vector of n elements, the last of them flagged. Now and then a weight word is
	// slipped in between the elements, sometimes with last set, which the engine must ignore.
	task automatic stream_vector(int unsigned n);
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_item(1'b0, 10'($urandom), pick_value(), 1'($urandom));
			send_item(1'b1, 10'($urandom), pick_value(), i + 1 == n);
		end
	endtask

	function automatic int unsigned vector_length();
		case ($urandom_range(0, 5))
			0: return $urandom_range(1, 4);
			1: return $urandom_range(17, 20);
			default: return $urandom_range(5, 16);
		endcase
	endfunction

	// Every weight word that a network below can read is written before the first pass: the
	// full input width of layer zero, the full output width of layer three and HID_MAX square
	// blocks elsewhere. The networks keep widths one to three within HID_MAX.
	task automatic test_weight_preload();
		for (int unsigned l = 0; l < 4; l++)
			for (int unsigned r = 0; r < 16; r++)
				for (int unsigned c = 0; c < 16; c++)
					if ((l == 0 && r < HID_MAX) || (l == 3 && c < HID_MAX)
							|| (r < HID_MAX && c < HID_MAX))
						send_item(1'b0, 10'(l * 256 + r * 16 + c), pick_value(), 1'($urandom));
	endtask

	task automatic test_directed_corners();
		// Two-layer network of single nodes, most negative scale.
		set_network(16'h8000, 3'd2, 5'd1, 5'd1, 5'd16, 5'd16, 5'd16);
		send_item(1'b1, 10'h3ff, 16'sh7fff, 1'b1);
		send_item(1'b1, 10'h000, 16'sh8000, 1'b1);
		// Default depth at full input width: a short vector leaves missing features at zero,
		// a long one overflows the feature store and the surplus is dropped.
		set_network(16'h7fff, 3'd3, 5'd16, 5'd5, 5'd4, 5'd16, 5'd16);
		send_item(1'b0, 10'd0, 16'sh7fff, 1'b1);
		send_item(1'b1, 10'h2aa, 16'sh7fff, 1'b1);
		stream_vector(18);
		// Register values outside their ranges clamp: depth 0 acts as 2, width 31 as sixteen
		// and width 0 as 1.
		set_network(16'h0000, 3'd0, 5'd31, 5'd0, 5'd0, 5'd0, 5'd0);
		send_item(1'b1, 10'h155, 16'sh0000, 1'b1);
		// Depth 7 acts as five layers; widths 31 on the outer layers act as sixteen.
		set_network(16'h1000, 3'd7, 5'd31, 5'd0, 5'd5, 5'd5, 5'd31);
		stream_vector(2);
	endtask

	task automatic test_backpressure();
		set_network(16'h1000, 3'd4, 5'd8, 5'd5, 5'd4, 5'd3, 5'd16);
		// The receiver holds off while several vectors queue up behind the running pass.
		hold_seq++;
		for (int i = 0; i < 4; i++) stream_vector($urandom_range(4, 9));
		// The sender then waits until everything owed has arrived before going on.
		drain_outputs();
		stream_vector(8);
	endtask

	task automatic test_random_networks();
		for (int s = 0; s < 6; s++) begin
			set_network(pick_value(), 3'($urandom_range(0, 7)), 5'($urandom_range(0, 18)),
				5'($urandom_range(0, HID_MAX)), 5'($urandom_range(0, HID_MAX)),
				5'($urandom_range(0, HID_MAX)), 5'($urandom_range(0, 18)));
			for (int v = 0; v < 2; v++) begin
				if ($urandom_range(0, 2) == 0)
					repeat ($urandom_range(1, 6)) send_item(1'b0, 10'($urandom), pick_value(), 1'($urandom));
				stream_vector(vector_length());
			end
		end
	endtask

	task automatic test_steady_stream();
		set_network(16'h1800, 3'd5, 5'd16, 5'd5, 5'd4, 5'd3, 5'd16);
		drain_outputs();
		quiet = 1'b1;
		for (int v = 0; v < 2; v++) stream_vector(16);
		park_input();
	endtask

	// Result side: ready comes in random bursts, goes solid high near the end and is held low
	// for a long stretch whenever the stimulus asks for it.
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned burst_left = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else if (hold_seq != hold_seen) begin
			hold_seen <= hold_seq;
			hold_left <= HOLD_CYCLES;
			result_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_ready <= 1'b0;
		end else if (quiet) begin
			result_ready <= 1'b1;
		end else if (burst_left != 0) begin
			burst_left <= burst_left - 1;
		end else begin
			burst_left <= $urandom_range(1, 18);
			result_ready <= ($urandom_range(0, 2) != 0);
		end
	end

	// Outputs are sampled at the falling edge, where everything driven at the rising edge has
	// settled, so a transaction seen here completes at the next rising edge.
	int unsigned quiet_cycles = 0;
	always @(negedge clk) begin
		node_result_t want;
		if (arst_n && result_valid && result_ready) begin
			results_seen++;
			if (pending_outputs.size() == 0) begin
				$error("unexpected result: out_value %0d out_index %0d", out_value, out_index);
				errors++;
			end else begin
				want = pending_outputs.pop_front();
				if (out_value !== want.value) begin
					$error("out_value: expected %0d, got %0d", want.value, out_value);
					errors++;
				end
				if (out_index !== want.index) begin
					$error("out_index: expected %0d, got %0d", want.index, out_index);
					errors++;
				end
				if (out_last !== want.last) begin
					$error("out_last: expected %0d, got %0d", want.last, out_last);
					errors++;
				end
			end
		end
		if ((item_valid && item_ready) || (result_valid && result_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", pending_outputs.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		build_logistic();
		features_held = 0;
		scale_sh = 16'sh1000;
		depth_sh = 3'd3;
		for (int i = 0; i < 5; i++) width_sh[i] = 5'd16;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_weight_preload();
		test_directed_corners();
		test_backpressure();
		test_random_networks();
		test_steady_stream();
		park_input();
		while (pending_outputs.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("Sent %0d transactions over %0d forward passes; checked %0d output nodes.",
			items_sent, passes_run, results_seen);
		$display("Depths two to five, widths one to sixteen, clamped registers and stalls covered.");
		if (errors == 0 && pending_outputs.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
